// File: sv/tcit_pkg.sv
// Package for the three-channel interval timer: widths, codes, reset constants
// and BCD conversion helpers. No dependencies.
package tcit_pkg;

    localparam int unsigned CHANNELS_DEF = 3;
    localparam logic [31:0] INPUT_RATE_RST = 32'd1193182;
    localparam logic [31:0] CYCLE_RATE_RST = 32'd4772728;
    localparam logic [16:0] FULL_BIN = 17'd65536;
    localparam logic [16:0] FULL_BCD = 17'd10000;

    typedef enum logic [1:0] {
        K_READ  = 2'd0,
        K_WRITE = 2'd1,
        K_CYCLE = 2'd2,
        K_NOP   = 2'd3
    } t_kind;

    localparam logic [1:0] PORT_CTRL = 2'd3;
    localparam logic       REG_INPUT_RATE = 1'b0;
    localparam logic       REG_CYCLE_RATE = 1'b1;

    localparam logic [1:0] AM_LATCH = 2'd0;
    localparam logic [1:0] AM_LOW   = 2'd1;
    localparam logic [1:0] AM_HIGH  = 2'd2;
    localparam logic [1:0] AM_BOTH  = 2'd3;

    // 16-bit BCD word to binary (each digit weighted by a constant)
    function automatic logic [15:0] bcd_to_bin(input logic [15:0] v);
        logic [15:0] r;
        r = 16'(v[3:0]) + 16'(v[7:4]) * 16'd10 + 16'(v[11:8]) * 16'd100
            + 16'(v[15:12]) * 16'd1000;
        return r;
    endfunction

    // Low 4 decimal digits of a 17-bit value. Quotients by 10, 100, 1000 and
    // 10000 come in parallel from reciprocal multiplies, exact over 17 bits.
    function automatic logic [15:0] bin_to_bcd(input logic [16:0] n);
        logic [34:0] p1, p2, p3, p4;
        logic [16:0] q1, q2, q3, q4;
        logic [15:0] v;
        p1 = 35'(n) * 35'd104858;
        p2 = 35'(n) * 35'd167773;
        p3 = 35'(n) * 35'd134218;
        p4 = 35'(n) * 35'd214749;
        q1 = 17'(p1 >> 20);
        q2 = 17'(p2 >> 24);
        q3 = 17'(p3 >> 27);
        q4 = 17'(p4 >> 31);
        v[3:0]   = 4'(n - q1 * 17'd10);
        v[7:4]   = 4'(q1 - q2 * 17'd10);
        v[11:8]  = 4'(q2 - q3 * 17'd10);
        v[15:12] = 4'(q3 - q4 * 17'd10);
        return v;
    endfunction

endpackage

// File: sv/three_channel_interval_timer.sv
// Three-channel interval timer, top level.
// Depends on tcit_pkg.
//
// Usage: one item per transaction on the input channel (i_mode, i_port,
// i_data, i_gates): a port read, a port write, or a system cycle carrying
// the gate levels. Every item yields exactly one result (o_read_data,
// o_out_levels, o_irq0) on the output channel.
// Output: the result is registered into the output register, or into the
// skid slot while the output is stalled. Throughput: one item per clock while
// o_ready is high; the item is processed in a single pass from the channel
// state registers into the result register. The skid keeps input ready high
// while one result waits; ready drops only when both slots are full.
// Configuration: i_cfg_index 0 = input rate, 1 = cycle rate; a zero write
// is ignored. Written only while idle: a rule for the user; the block does not enforce it.
// Reset (synchronous, active low): all channels cleared, gates read high,
// phase zero, rates back to their defaults, output slots empty.
module three_channel_interval_timer
    import tcit_pkg::*;
#(
    parameter int unsigned CHANNELS = CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [1:0]  i_port,
    input  logic [7:0]  i_data,
    input  logic [2:0]  i_gates,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_data,
    output logic [2:0]  o_out_levels,
    output logic        o_irq0,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    typedef struct packed {
        logic [16:0] counter;
        logic [15:0] reload;
        logic [16:0] cnt_latch;
        logic [7:0]  st_latch;
        logic [1:0]  access;
        logic [2:0]  cmode;
        logic        bcd;
        logic        cnt_latched;
        logic        st_latched;
        logic        rd_hi;
        logic        wr_hi;
        logic        null_cnt;
        logic        running;
        logic        out_lvl;
        logic        gate_now;
        logic        gate_bef;
    } t_chan;

    typedef struct packed {
        logic [7:0] rd;
        logic [2:0] lv;
        logic       irq;
    } t_res;

    t_chan       r_ch [CHANNELS];
    t_chan       n_ch [CHANNELS];
    logic [31:0] r_phase, n_phase;
    logic        r_irq, n_irq;
    logic [31:0] r_in_rate, r_cyc_rate;
    t_res        r_out, r_skid, n_res;
    logic        r_out_v, r_skid_v;
    logic        acc;

    assign o_ready     = !r_skid_v;
    assign o_cfg_ready = 1'b1;
    assign acc         = i_valid && o_ready;
    assign o_valid      = r_out_v;
    assign o_read_data  = r_out.rd;
    assign o_out_levels = r_out.lv;
    assign o_irq0       = r_out.irq;

    function automatic logic [16:0] start_val(input t_chan c);
        if (c.reload == 16'd0) return c.bcd ? FULL_BCD : FULL_BIN;
        return {1'b0, c.reload};
    endfunction

    function automatic t_chan load_c(input t_chan c);
        t_chan r;
        r = c;
        r.counter  = start_val(c);
        r.running  = 1'b1;
        r.null_cnt = 1'b0;
        r.out_lvl  = !(c.cmode == 3'd0 || c.cmode == 3'd1);
        return r;
    endfunction

    function automatic t_chan latch_cnt(input t_chan c);
        t_chan r;
        r = c;
        if (!c.cnt_latched) begin
            r.cnt_latch   = c.counter;
            r.cnt_latched = 1'b1;
        end
        return r;
    endfunction

    function automatic t_chan count_once(input t_chan ci, output logic irq);
        t_chan       c;
        logic [16:0] rc;
        logic [2:0]  m;
        logic        rising;
        c      = ci;
        irq    = 1'b0;
        rc     = start_val(ci);
        m      = ci.cmode;
        rising = ci.gate_now && !ci.gate_bef;
        if ((m == 3'd1 || m == 3'd5) && rising) begin
            c = load_c(c);
            c.out_lvl = (m == 3'd5);
        end
        if ((m == 3'd2 || m == 3'd3) && !c.gate_now) begin
            c.out_lvl = 1'b1;
        end else begin
            if ((m == 3'd2 || m == 3'd3) && rising) c = load_c(c);
            if (c.running && c.gate_now && c.counter != 17'd0) begin
                if (m == 3'd2) begin
                    if (!c.out_lvl) begin
                        c.out_lvl = 1'b1;
                        c.counter = (rc > 17'd1) ? rc - 17'd1 : 17'd1;
                    end else if (c.counter > 17'd1) begin
                        c.counter = c.counter - 17'd1;
                    end else begin
                        c.out_lvl = 1'b0;
                        c.counter = rc;
                        irq       = 1'b1;
                    end
                end else if (m == 3'd3) begin
                    if (c.counter > 17'd1) begin
                        c.counter = c.counter - 17'd1;
                    end else if (c.out_lvl) begin
                        c.out_lvl = 1'b0;
                        c.counter = rc >> 1;
                    end else begin
                        c.out_lvl = 1'b1;
                        c.counter = 17'((18'(rc) + 18'd1) >> 1);
                    end
                end else if (c.counter > 17'd1) begin
                    c.counter = c.counter - 17'd1;
                end else if (m == 3'd4 || m == 3'd5) begin
                    c.out_lvl = !c.out_lvl;
                    if (c.out_lvl) c.running = 1'b0;
                    else c.counter = 17'd1;
                end else begin
                    c.counter = 17'd0;
                    c.out_lvl = 1'b1;
                    c.running = 1'b0;
                end
            end
        end
        return c;
    endfunction

    logic [31:0] add_amt;
    logic [32:0] sum;
    logic        tick;
    assign add_amt = (r_in_rate < r_cyc_rate) ? r_in_rate : r_cyc_rate;
    assign sum     = {1'b0, r_phase} + {1'b0, add_amt};
    assign tick    = sum >= {1'b0, r_cyc_rate};

    always_comb begin
        t_chan       c;
        logic [15:0] shv;
        logic [7:0]  b;
        logic [15:0] r16;
        logic        ir;
        logic [1:0]  sel;
        c       = '0;
        shv     = '0;
        b       = '0;
        r16     = '0;
        ir      = 1'b0;
        n_phase = r_phase;
        n_irq   = r_irq;
        n_res   = '0;
        for (int j = 0; j < CHANNELS; j++) n_ch[j] = r_ch[j];
        sel = i_data[7:6];
        unique case (t_kind'(i_mode))
            K_READ: begin
                for (int j = 0; j < CHANNELS; j++) begin
                    if (i_port == 2'(j)) begin
                        c = r_ch[j];
                        if (c.st_latched) begin
                            c.st_latched = 1'b0;
                            n_res.rd     = c.st_latch;
                        end else begin
                            shv = c.bcd ? bin_to_bcd(c.cnt_latched ? c.cnt_latch : c.counter)
                                        : (c.cnt_latched ? c.cnt_latch[15:0] : c.counter[15:0]);
                            b = (c.access == AM_HIGH || (c.access == AM_BOTH && c.rd_hi))
                                ? shv[15:8] : shv[7:0];
                            n_res.rd = b;
                            if (c.access == AM_BOTH) begin
                                c.rd_hi = !c.rd_hi;
                                if (!c.rd_hi) c.cnt_latched = 1'b0;
                            end else begin
                                c.cnt_latched = 1'b0;
                            end
                        end
                        n_ch[j] = c;
                    end
                end
            end
            K_WRITE: begin
                for (int j = 0; j < CHANNELS; j++) begin
                    c = r_ch[j];
                    if (i_port == PORT_CTRL) begin
                        if (sel == 2'd3) begin
                            if (!i_data[j+1]) begin
                                if (!i_data[5]) c = latch_cnt(c);
                                if (!i_data[4] && !c.st_latched) begin
                                    c.st_latch = {c.out_lvl, c.null_cnt, c.access, c.cmode,
                                                  c.bcd};
                                    c.st_latched = 1'b1;
                                end
                            end
                        end else if (sel == 2'(j)) begin
                            if (i_data[5:4] == AM_LATCH) begin
                                c = latch_cnt(c);
                            end else begin
                                c.access      = i_data[5:4];
                                c.cmode       = (i_data[3:1] > 3'd5) ? {1'b0, i_data[2:1]}
                                                                      : i_data[3:1];
                                c.bcd         = i_data[0];
                                c.rd_hi       = 1'b0;
                                c.wr_hi       = 1'b0;
                                c.cnt_latched = 1'b0;
                                c.st_latched  = 1'b0;
                                c.null_cnt    = 1'b1;
                            end
                        end
                    end else if (i_port == 2'(j)) begin
                        if (c.access == AM_LOW) begin
                            c.reload = c.bcd ? bcd_to_bin({8'd0, i_data}) : {8'd0, i_data};
                            c = load_c(c);
                        end else if (c.access == AM_HIGH) begin
                            c.reload = c.bcd ? bcd_to_bin({i_data, 8'd0}) : {i_data, 8'd0};
                            c = load_c(c);
                        end else if (!c.wr_hi) begin
                            r16 = c.bcd ? bcd_to_bin({8'd0, i_data}) : {8'd0, i_data};
                            c.reload   = {c.reload[15:8], 8'd0} | r16;
                            c.wr_hi    = 1'b1;
                            c.null_cnt = 1'b1;
                        end else begin
                            shv = c.bcd ? bin_to_bcd({1'b0, c.reload}) : c.reload;
                            c.reload = c.bcd ? bcd_to_bin({i_data, shv[7:0]})
                                             : {i_data, c.reload[7:0]};
                            c.wr_hi = 1'b0;
                            c = load_c(c);
                        end
                    end
                    n_ch[j] = c;
                end
            end
            K_CYCLE: begin
                n_irq   = 1'b0;
                n_phase = tick ? 32'(sum - {1'b0, r_cyc_rate}) : sum[31:0];
                for (int j = 0; j < CHANNELS; j++) begin
                    c = r_ch[j];
                    c.gate_bef = c.gate_now;
                    c.gate_now = i_gates[j];
                    if (tick) begin
                        c = count_once(c, ir);
                        if (j == 0 && ir) n_irq = 1'b1;
                    end
                    n_ch[j] = c;
                end
            end
            default: ;
        endcase
        for (int j = 0; j < CHANNELS; j++) n_res.lv[j] = n_ch[j].out_lvl;
        n_res.irq = n_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < CHANNELS; j++) begin
                r_ch[j] <= '{gate_now: 1'b1, default: '0};
            end
            r_phase    <= '0;
            r_irq      <= 1'b0;
            r_in_rate  <= INPUT_RATE_RST;
            r_cyc_rate <= CYCLE_RATE_RST;
            r_out_v    <= 1'b0;
            r_skid_v   <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_data != 32'd0) begin
                if (i_cfg_index == REG_INPUT_RATE) r_in_rate <= i_cfg_data;
                else r_cyc_rate <= i_cfg_data;
            end
            if (acc) begin
                for (int j = 0; j < CHANNELS; j++) r_ch[j] <= n_ch[j];
                r_phase <= n_phase;
                r_irq   <= n_irq;
            end
            // two-slot output: skid holds a result while the output slot is stalled
            if (!r_out_v || i_ready) begin
                if (r_skid_v) begin
                    r_out    <= r_skid;
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end else begin
                    r_out   <= n_res;
                    r_out_v <= acc;
                end
            end else if (acc) begin
                r_skid   <= n_res;
                r_skid_v <= 1'b1;
            end
        end
    end

endmodule
